// ===== rtl/gma_pkg.sv =====
// ============================================================================
// Gated moving average package
// Shared widths, reset values, register indexes and sequencer states.
// ============================================================================
package gma_pkg;

    localparam int WINDOW      = 60;
    localparam int RATE_W      = 12;
    localparam int COUNT_OUT_W = 6;
    localparam int SLOT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int COUNT_W     = $clog2(WINDOW + 1);
    localparam int SUM_W       = $clog2(WINDOW * ((1 << RATE_W) - 1) + 1);
    localparam int DIV_CNT_W   = $clog2(SUM_W + 1);

    localparam int IN_TDATA_W  = ((RATE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RATE_W + COUNT_OUT_W + 7) / 8) * 8;

    localparam int CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE = 1'b1;

    localparam logic [RATE_W-1:0] MIN_RATE_RST = 12'd640;
    localparam logic [RATE_W-1:0] MAX_RATE_RST = 12'd2880;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_START,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/gated_moving_average_unit.sv =====
// ============================================================================
// Gated moving average unit
// Range-gated moving average of heart-rate samples over a ring window.
// ============================================================================
// Usage:
//   Samples (unsigned Q8.4 bpm) enter on the s_axis channel, one per
//   transaction. Each sample yields exactly one result transaction on the
//   m_axis channel: the window average, the accepted flag in tuser and the
//   number of samples held in the window.
//   A sample inside [min_rate, max_rate] replaces the oldest window entry and
//   the average is recomputed by a restoring divider, one quotient bit per
//   cycle; a rejected sample repeats the previous average. s_axis_tready is
//   low while a sample is being processed, so the unit takes no new sample
//   before the result of the last one is loaded into the output register.
//   The result sits in an output register; if the receiver stalls, it holds
//   there, and a following sample is processed but waits before its result.
//   Reset empties the window, clears sum and average, and loads the range
//   registers with 40.0 and 180.0 bpm. The window needs no clearing pass.
//   Range registers are written through cfg_we/cfg_index/cfg_data while idle; the user must ensure this.
// ============================================================================
module gated_moving_average_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gma_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gma_pkg::RATE_W-1:0]        cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [11:0] sample_rate, upper bits unused
    input  logic [gma_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [11:0] average_rate, [17:12] valid_count, upper bits zero
    output logic [gma_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [0] accepted
    output logic                              m_axis_tuser
);

    gma_pkg::state_t state_reg, state_next;

    logic [gma_pkg::RATE_W-1:0]  min_rate_reg, max_rate_reg;
    logic [gma_pkg::RATE_W-1:0]  sample_reg, sample_next;
    logic                        take_reg, take_next;
    logic [gma_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [gma_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic [gma_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [gma_pkg::RATE_W-1:0]  last_avg_reg, last_avg_next;
    logic [gma_pkg::RATE_W-1:0]  rd_data_reg;
    logic [gma_pkg::RATE_W-1:0]  old_entry;

    logic                        out_valid_reg, out_valid_next;
    logic [gma_pkg::RATE_W-1:0]  out_avg_reg, out_avg_next;
    logic                        out_take_reg, out_take_next;
    logic [gma_pkg::COUNT_OUT_W-1:0] out_cnt_reg, out_cnt_next;

    logic                        in_fire;
    logic                        in_range;
    logic                        mem_we;
    logic                        div_start;
    logic                        div_done;
    logic                        emit_load;
    logic                        window_full;
    logic [gma_pkg::SUM_W-1:0]   quotient;

    logic [gma_pkg::RATE_W-1:0] win_mem [gma_pkg::WINDOW];

    assign in_fire     = s_axis_tvalid && s_axis_tready;
    assign in_range    = (s_axis_tdata[gma_pkg::RATE_W-1:0] >= min_rate_reg) &&
                         (s_axis_tdata[gma_pkg::RATE_W-1:0] <= max_rate_reg);
    assign window_full = (count_reg == gma_pkg::COUNT_W'(gma_pkg::WINDOW));
    // Slots at or above the fill count were never written and stand for zero.
    assign old_entry   = window_full ? rd_data_reg : '0;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gma_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = in_range ? gma_pkg::ST_READ : gma_pkg::ST_EMIT;
                end
            end
            gma_pkg::ST_READ:   state_next = gma_pkg::ST_UPDATE;
            gma_pkg::ST_UPDATE: state_next = gma_pkg::ST_START;
            gma_pkg::ST_START:  state_next = gma_pkg::ST_DIVIDE;
            gma_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = gma_pkg::ST_EMIT;
                end
            end
            gma_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = gma_pkg::ST_IDLE;
                end
            end
            default: state_next = gma_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        div_start     = 1'b0;
        emit_load     = 1'b0;
        case (state_reg)
            gma_pkg::ST_IDLE:   s_axis_tready = 1'b1;
            gma_pkg::ST_UPDATE: mem_we        = 1'b1;
            gma_pkg::ST_START:  div_start     = 1'b1;
            gma_pkg::ST_EMIT:   emit_load     = !out_valid_reg || m_axis_tready;
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        sample_next   = sample_reg;
        take_next     = take_reg;
        sum_next      = sum_reg;
        slot_next     = slot_reg;
        count_next    = count_reg;
        last_avg_next = last_avg_reg;
        if (in_fire)
        begin
            sample_next = s_axis_tdata[gma_pkg::RATE_W-1:0];
            take_next   = in_range;
        end
        if (mem_we)
        begin
            sum_next  = sum_reg - gma_pkg::SUM_W'(old_entry)
                        + gma_pkg::SUM_W'(sample_reg);
            slot_next = (slot_reg == gma_pkg::SLOT_W'(gma_pkg::WINDOW - 1)) ?
                        '0 : slot_reg + 1'b1;
            if (!window_full)
            begin
                count_next = count_reg + 1'b1;
            end
        end
        if (div_done)
        begin
            last_avg_next = quotient[gma_pkg::RATE_W-1:0];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_avg_next   = out_avg_reg;
        out_take_next  = out_take_reg;
        out_cnt_next   = out_cnt_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit_load)
        begin
            out_valid_next = 1'b1;
            out_avg_next   = last_avg_reg;
            out_take_next  = take_reg;
            out_cnt_next   = gma_pkg::COUNT_OUT_W'(count_reg);
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gma_pkg::ST_IDLE;
            min_rate_reg  <= gma_pkg::MIN_RATE_RST;
            max_rate_reg  <= gma_pkg::MAX_RATE_RST;
            take_reg      <= 1'b0;
            sum_reg       <= '0;
            slot_reg      <= '0;
            count_reg     <= '0;
            last_avg_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            take_reg      <= take_next;
            sum_reg       <= sum_next;
            slot_reg      <= slot_next;
            count_reg     <= count_next;
            last_avg_reg  <= last_avg_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == gma_pkg::REG_MIN_RATE))
            begin
                min_rate_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == gma_pkg::REG_MAX_RATE))
            begin
                max_rate_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        out_avg_reg  <= out_avg_next;
        out_take_reg <= out_take_next;
        out_cnt_reg  <= out_cnt_next;
    end

    // Window ring: one write and one registered read per cycle, both at the
    // oldest slot.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            win_mem[slot_reg] <= sample_reg;
        end
        rd_data_reg <= win_mem[slot_reg];
    end

    gma_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = gma_pkg::OUT_TDATA_W'({out_cnt_reg, out_avg_reg});
    assign m_axis_tuser  = out_take_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= gma_pkg::COUNT_W'(gma_pkg::WINDOW))
        else $error("fill count above window size");

    a_slot_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        !window_full |-> (gma_pkg::COUNT_W'(slot_reg) == count_reg))
        else $error("write slot out of step with fill count");

    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == gma_pkg::ST_DIVIDE))
        else $error("divider finished outside the divide state");

    a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && take_reg) |-> (count_reg != '0))
        else $error("accepted result with an empty window");

endmodule

// ===== rtl/gma_divider.sv =====
// ============================================================================
// Gated moving average divider
// Restoring divider that retires one quotient bit per cycle.
// ============================================================================
module gma_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [gma_pkg::SUM_W-1:0]   dividend,
    input  logic [gma_pkg::COUNT_W-1:0] divisor,
    output logic                       done,
    output logic [gma_pkg::SUM_W-1:0]   quotient
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [gma_pkg::DIV_CNT_W-1:0]  iter_reg, iter_next;
    logic [gma_pkg::COUNT_W-1:0]    rem_reg, rem_next;
    logic [gma_pkg::SUM_W-1:0]      quo_reg, quo_next;
    logic [gma_pkg::COUNT_W-1:0]    div_reg, div_next;
    logic [gma_pkg::COUNT_W:0]      trial;
    logic [gma_pkg::COUNT_W:0]      diff;
    logic                           fits;

    // Shift in the next dividend bit and try to take the divisor off.
    assign trial = {rem_reg, quo_reg[gma_pkg::SUM_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[gma_pkg::COUNT_W-1:0] : trial[gma_pkg::COUNT_W-1:0];
            quo_next  = {quo_reg[gma_pkg::SUM_W-2:0], fits};
            iter_next = iter_reg + 1'b1;
            if (iter_reg == gma_pkg::DIV_CNT_W'(gma_pkg::SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
